/* hdl/msb_pkg.sv */
// shared types and constants for the masked sprite pixel blitter
package msb_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_CENTER_X  = 2'd0;
  localparam logic [1:0] REG_GROUND_Y  = 2'd1;
  localparam logic [1:0] REG_MIRROR    = 2'd2;
  localparam logic [1:0] REG_COLOR_MODE = 2'd3;

  // colour effect codes, code 3 behaves as unchanged
  localparam logic [1:0] CM_NONE = 2'd0;
  localparam logic [1:0] CM_GRAY = 2'd1;
  localparam logic [1:0] CM_DARK = 2'd2;

  // luma weights and divide by 100 as multiply by 2^19/100 rounded up
  localparam int LUMA_R_W   = 30;
  localparam int LUMA_G_W   = 59;
  localparam int LUMA_B_W   = 11;
  localparam int DIV_RECIP  = 5243;
  localparam int DIV_SHIFT  = 19;
  localparam logic [15:0] DARK_MASK = 16'h7BEF;

  localparam int COORD_W = 12;
  localparam int COLOR_W = 16;
  localparam int SUM_W   = 15;
  localparam int PROD_W  = 28;

  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  typedef struct packed {
    logic [10:0] center_x;
    logic [10:0] ground_y;
    logic        mirror;
    logic [1:0]  color_mode;
  } msb_cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] base_x;
    logic [COORD_W-1:0] base_y;
    logic [COLOR_W-1:0] color;
  } msb_item_t;

  typedef struct packed {
    logic not_empty;
    logic not_full;
  } fifo_stat_t;

endpackage

/* hdl/msb_front.sv */
// front end: accepts source words, drops transparent ones, computes corner and colour
module msb_front #(
  parameter int SPRITE_W = 32,
  parameter int SPRITE_H = 32,
  parameter int SCALE    = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  msb_pkg::msb_cfg_t   cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [4:0]          in_src_col,
  input  logic [4:0]          in_src_row,
  input  logic                in_opaque,
  input  logic [15:0]         in_pixel_color,
  input  msb_pkg::fifo_stat_t fifo_stat,
  output logic                push,
  output msb_pkg::msb_item_t  push_item
);
  import msb_pkg::*;

  localparam logic [COORD_W-1:0] HALF_W  = COORD_W'((SPRITE_W * SCALE) / 2);
  localparam logic [COORD_W-1:0] FULL_H  = COORD_W'(SPRITE_H * SCALE);
  localparam logic [COORD_W-1:0] LAST_COL = COORD_W'(SPRITE_W - 1);
  localparam logic [COORD_W-1:0] SCALE_C = COORD_W'(SCALE);

  logic                v1_r;
  logic [COORD_W-1:0]  base_x_r, base_y_r;
  logic [COLOR_W-1:0]  color_r;
  logic [SUM_W-1:0]    sum_r;
  logic [1:0]          mode_r;

  logic [COORD_W-1:0]  dcol, base_x_nxt, base_y_nxt;
  logic [7:0]          r8, g8, b8, luma;
  logic [SUM_W-1:0]    sum_nxt;
  logic [PROD_W-1:0]   prod;
  logic [COLOR_W-1:0]  color_out;
  logic                take;

  assign take     = in_valid && in_ready;
  assign in_ready = !v1_r || fifo_stat.not_full;
  assign push     = v1_r && fifo_stat.not_full;

  always_comb begin
    dcol = cfg.mirror ? (LAST_COL - {7'd0, in_src_col}) : {7'd0, in_src_col};
    base_x_nxt = {cfg.center_x[10], cfg.center_x} - HALF_W + COORD_W'(dcol * SCALE_C);
    base_y_nxt = {cfg.ground_y[10], cfg.ground_y} - FULL_H
                 + COORD_W'({7'd0, in_src_row} * SCALE_C);
    r8 = {in_pixel_color[15:11], in_pixel_color[15:13]};
    g8 = {in_pixel_color[10:5], in_pixel_color[10:9]};
    b8 = {in_pixel_color[4:0], in_pixel_color[4:2]};
    sum_nxt = SUM_W'(LUMA_R_W * r8 + LUMA_G_W * g8 + LUMA_B_W * b8);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (take) begin
      v1_r <= in_opaque;
    end else if (push) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      base_x_r <= base_x_nxt;
      base_y_r <= base_y_nxt;
      color_r  <= in_pixel_color;
      sum_r    <= sum_nxt;
      mode_r   <= cfg.color_mode;
    end
  end

  // luma = sum / 100, exact over the whole sum range
  always_comb begin
    prod = PROD_W'(sum_r) * PROD_W'(DIV_RECIP);
    luma = prod[DIV_SHIFT +: 8];
    unique case (mode_r)
      CM_GRAY: color_out = {luma[7:3], luma[7:2], luma[7:3]};
      CM_DARK: color_out = {1'b0, color_r[15:1]} & DARK_MASK;
      default: color_out = color_r;
    endcase
  end

  assign push_item = '{base_x: base_x_r, base_y: base_y_r, color: color_out};

  a_transparent_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_opaque) |=> !v1_r)
    else $error("transparent word entered the front stage");

endmodule

/* hdl/msb_fifo.sv */
// short queue between the front end and the write sequencer
module msb_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  msb_pkg::msb_item_t  push_item,
  input  logic                pop,
  output msb_pkg::msb_item_t  head,
  output msb_pkg::fifo_stat_t stat
);
  import msb_pkg::*;

  msb_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{FIFO_AW{1'b0}}, push} - {{FIFO_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head           = mem_r[rd_ptr_r];
  assign stat.not_empty = (count_r != '0);
  assign stat.not_full  = (count_r != (FIFO_AW+1)'(FIFO_DEPTH));

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue fill count beyond depth");

endmodule

/* hdl/msb_back.sv */
// back end: walks the scaled block row-major and drives the output register
module msb_back #(
  parameter int SCALE = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  msb_pkg::msb_item_t  head,
  input  msb_pkg::fifo_stat_t fifo_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [11:0]         out_dest_x,
  output logic [11:0]         out_dest_y,
  output logic [15:0]         out_out_color,
  output logic                out_last_write
);
  import msb_pkg::*;

  localparam int SW = (SCALE > 1) ? $clog2(SCALE) : 1;
  localparam logic [SW-1:0] LAST_S = SW'(SCALE - 1);

  logic                out_valid_r, last_r;
  logic [COORD_W-1:0]  dest_x_r, dest_y_r;
  logic [COLOR_W-1:0]  color_r;
  logic [SW-1:0]       sx_r, sy_r, sx_nxt, sy_nxt;
  logic                out_take, load, last_x, last_y;

  assign out_take = !out_valid_r || out_ready;
  assign load     = out_take && fifo_stat.not_empty;
  assign last_x   = (sx_r == LAST_S);
  assign last_y   = (sy_r == LAST_S);
  assign pop      = load && last_x && last_y;

  always_comb begin
    sx_nxt = sx_r;
    sy_nxt = sy_r;
    if (load) begin
      if (last_x) begin
        sx_nxt = '0;
        sy_nxt = last_y ? '0 : sy_r + 1'b1;
      end else begin
        sx_nxt = sx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sx_r        <= '0;
      sy_r        <= '0;
    end else begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
      if (out_take) begin
        out_valid_r <= fifo_stat.not_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dest_x_r <= head.base_x + COORD_W'(sx_r);
      dest_y_r <= head.base_y + COORD_W'(sy_r);
      color_r  <= head.color;
      last_r   <= last_x && last_y;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dest_x     = dest_x_r;
  assign out_dest_y     = dest_y_r;
  assign out_out_color  = color_r;
  assign out_last_write = last_r;

  a_block_in_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (sx_r != '0 || sy_r != '0) |-> fifo_stat.not_empty)
    else $error("block walk under way with no queued word");

endmodule

/* hdl/masked_sprite_pixel_blit_top.sv */
// top level of the masked sprite pixel blitter
// an opaque word passes the front stage register and the queue into the output register
// each opaque word gives SCALE*SCALE writes, which the back end makes one pixel per cycle
//   while out_ready allows; transparent words, taken one per cycle while in_ready holds, give no write
// a four-entry queue lets the front keep accepting while the back is walking a block
// reset (synchronous, active low) empties the front stage and queue, config regs go to 0
module masked_sprite_pixel_blit_top #(
  parameter int SPRITE_W = 32,
  parameter int SPRITE_H = 32,
  parameter int SCALE    = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  // source words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_src_col,
  input  logic [4:0]  in_src_row,
  input  logic        in_opaque,
  input  logic [15:0] in_pixel_color,
  // canvas writes
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_dest_x,
  output logic [11:0] out_dest_y,
  output logic [15:0] out_out_color,
  output logic        out_last_write
);
  import msb_pkg::*;

  msb_cfg_t   cfg_r;
  msb_item_t  push_item, head;
  fifo_stat_t fifo_stat;
  logic       push, pop;

  // configuration registers, to be written only while the datapath is idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X:   cfg_r.center_x   <= cfg_data;
        REG_GROUND_Y:   cfg_r.ground_y   <= cfg_data;
        REG_MIRROR:     cfg_r.mirror     <= cfg_data[0];
        REG_COLOR_MODE: cfg_r.color_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // front: mask check, corner arithmetic, colour effect
  msb_front #(
    .SPRITE_W(SPRITE_W),
    .SPRITE_H(SPRITE_H),
    .SCALE   (SCALE)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_src_col    (in_src_col),
    .in_src_row    (in_src_row),
    .in_opaque     (in_opaque),
    .in_pixel_color(in_pixel_color),
    .fifo_stat     (fifo_stat),
    .push          (push),
    .push_item     (push_item)
  );

  // decoupling queue
  msb_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .stat     (fifo_stat)
  );

  // back: one canvas write per cycle while a word is queued and out_ready allows, row-major over the scaled block
  msb_back #(
    .SCALE(SCALE)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .fifo_stat     (fifo_stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_dest_x    (out_dest_x),
    .out_dest_y    (out_dest_y),
    .out_out_color (out_out_color),
    .out_last_write(out_last_write)
  );

endmodule
